>>> design/c_token_lexer_unit_defines.svh
// Assertion macros shared by the lexer checker.
`ifndef C_TOKEN_LEXER_UNIT_DEFINES_SVH
`define C_TOKEN_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, masked while rst_n is low.
`define CTL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctl check failed");

// Next-cycle implication, sampled on clk, masked while rst_n is low.
`define CTL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctl check failed");

`endif

>>> design/ctl_pkg.sv
// Types, constants and keyword table for the C token lexer.
`default_nettype none
package ctl_pkg;

    localparam int MAX_TOKEN_LEN  = 128;
    localparam int KEYWORD_COUNT  = 17;
    localparam int POSITION_WIDTH = 16;
    localparam int KW_MAX_LEN     = 8;

    localparam logic [3:0] CLS_KEYWORD    = 4'd0;
    localparam logic [3:0] CLS_IDENTIFIER = 4'd1;
    localparam logic [3:0] CLS_NUMBER     = 4'd2;
    localparam logic [3:0] CLS_ARITH      = 4'd3;
    localparam logic [3:0] CLS_RELATIONAL = 4'd4;
    localparam logic [3:0] CLS_ASSIGN     = 4'd5;
    localparam logic [3:0] CLS_INCR       = 4'd6;
    localparam logic [3:0] CLS_DECR       = 4'd7;
    localparam logic [3:0] CLS_AND        = 4'd8;
    localparam logic [3:0] CLS_OR         = 4'd9;
    localparam logic [3:0] CLS_NOT        = 4'd10;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_WORD    = 2'd1;
    localparam logic [1:0] MODE_NUMBER  = 2'd2;
    localparam logic [1:0] MODE_PENDING = 2'd3;

    // Keyword text, right-justified: last character in the low byte.
    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        64'("int"), 64'("return"), 64'("if"), 64'("else"), 64'("for"),
        64'("while"), 64'("do"), 64'("switch"), 64'("case"), 64'("break"),
        64'("continue"), 64'("default"), 64'("const"), 64'("char"),
        64'("float"), 64'("double"), 64'("void")
    };
    localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
        4'd3, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd4, 4'd5,
        4'd8, 4'd7, 4'd5, 4'd4, 4'd5, 4'd6, 4'd4
    };

    typedef logic [POSITION_WIDTH-1:0] pos_t;
    typedef logic [KEYWORD_COUNT-1:0]  kw_mask_t;

    typedef struct packed {
        logic [3:0] token_class;
        pos_t       token_start;
        logic [7:0] token_length;
        logic [4:0] keyword_index;
        logic [7:0] operator_char;
        logic       length_overflow;
        logic       last_of_run;
    } tok_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] pend;
        kw_mask_t   cand;
        logic [7:0] len;
        pos_t       start;
        pos_t       pos;
        logic       ovf;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode:  MODE_IDLE,
        pend:  8'd0,
        cand:  {KEYWORD_COUNT{1'b1}},
        len:   8'd0,
        start: '0,
        pos:   '0,
        ovf:   1'b0
    };

    // Character p of keyword k, zero past its end.
    function automatic logic [7:0] kw_byte(input int k, input logic [2:0] p);
        logic [3:0] sel;
        sel = KW_LEN[k] - 4'd1 - {1'b0, p};
        if ({1'b0, p} < KW_LEN[k]) begin
            return KW_TEXT[k][sel[2:0]*8 +: 8];
        end
        return 8'd0;
    endfunction

endpackage
`default_nettype wire

>>> design/ctl_if.sv
// Valid/ready channels for source bytes and tokens.
`default_nettype none
interface ctl_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_text;

    modport source (output valid, output char_in, output end_of_text, input ready);
    modport sink   (input valid, input char_in, input end_of_text, output ready);
endinterface

interface ctl_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_class;
    logic [15:0] token_start;
    logic [7:0]  token_length;
    logic [4:0]  keyword_index;
    logic [7:0]  operator_char;
    logic        length_overflow;
    logic        last_of_run;

    modport source (output valid, output token_class, output token_start,
                    output token_length, output keyword_index, output operator_char,
                    output length_overflow, output last_of_run, input ready);
    modport sink   (input valid, input token_class, input token_start,
                    input token_length, input keyword_index, input operator_char,
                    input length_overflow, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> design/c_token_lexer_unit.sv
// Byte-serial C lexer: one source byte in per cycle, one token out per cycle,
// while the token queue has room and the token sink is ready. A byte is taken
// in every cycle while the four-entry token queue has room for two tokens; its
// tokens enter the queue at the same clock edge and can leave the next cycle.
// A byte yields zero, one or two tokens, so throughput is one byte per cycle
// whenever the bytes average at most one token each and the token sink stays
// ready; the single token port is the limit otherwise. Keywords are recognized
// from a 17-entry candidate mask narrowed on each byte; end_of_text flushes any
// open token and restarts positions at zero for the next text.
`default_nettype none
module c_token_lexer_unit
    import ctl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    ctl_text_if.sink    text,
    ctl_tok_if.source   tokens
);

    typedef struct packed {
        logic v0;
        logic v1;
        tok_t t0;
        tok_t t1;
    } pair_t;

    lex_state_t state_reg, state_next;
    pair_t      res;

    tok_t       queue_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    logic       accept, pop;
    logic [1:0] npush;

    function automatic pair_t push(input pair_t r, input tok_t t);
        pair_t o;
        o = r;
        if (!r.v0) begin
            o.v0 = 1'b1;
            o.t0 = t;
        end else begin
            o.v1 = 1'b1;
            o.t1 = t;
        end
        return o;
    endfunction

    function automatic tok_t mk_tok(input logic [3:0] cls, input pos_t st,
                                    input logic [7:0] len, input logic [4:0] kw,
                                    input logic [7:0] op, input logic ovf);
        tok_t t;
        t.token_class     = cls;
        t.token_start     = st;
        t.token_length    = len;
        t.keyword_index   = kw;
        t.operator_char   = op;
        t.length_overflow = ovf;
        t.last_of_run     = 1'b0;
        return t;
    endfunction

    // Narrow the keyword candidates and count the byte, or saturate.
    function automatic lex_state_t extend(input lex_state_t s, input logic [7:0] b);
        lex_state_t o;
        o = s;
        if (s.len < 8'(MAX_TOKEN_LEN)) begin
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                if (s.len >= 8'(KW_MAX_LEN) || kw_byte(k, s.len[2:0]) != b) begin
                    o.cand[k] = 1'b0;
                end
            end
            o.len = s.len + 8'd1;
        end else begin
            o.ovf  = 1'b1;
            o.cand = '0;
        end
        return o;
    endfunction

    // Close whatever token is open and push it, if it yields one.
    function automatic pair_t emit_open(input pair_t r, input lex_state_t s);
        pair_t      o;
        logic       hit;
        logic [4:0] idx;
        o   = r;
        hit = 1'b0;
        idx = 5'd0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (s.cand[k] && {4'd0, KW_LEN[k]} == s.len) begin
                hit = 1'b1;
                idx = 5'(k);
            end
        end
        if (s.ovf) begin
            hit = 1'b0;
            idx = 5'd0;
        end
        if (s.mode == MODE_WORD) begin
            o = push(o, mk_tok(hit ? CLS_KEYWORD : CLS_IDENTIFIER, s.start, s.len,
                               idx, 8'd0, s.ovf));
        end else if (s.mode == MODE_NUMBER) begin
            o = push(o, mk_tok(CLS_NUMBER, s.start, s.len, 5'd0, 8'd0, s.ovf));
        end else if (s.mode == MODE_PENDING) begin
            if (s.pend == "+" || s.pend == "-") begin
                o = push(o, mk_tok(CLS_ARITH, s.start, 8'd1, 5'd0, s.pend, 1'b0));
            end else if (s.pend == "=") begin
                o = push(o, mk_tok(CLS_ASSIGN, s.start, 8'd1, 5'd0, s.pend, 1'b0));
            end else if (s.pend == "!") begin
                o = push(o, mk_tok(CLS_NOT, s.start, 8'd1, 5'd0, s.pend, 1'b0));
            end
        end
        return o;
    endfunction

    logic [7:0] b;
    logic       b_alpha, b_digit, b_pend_op, b_single_op;
    logic [3:0] pair_cls;

    assign b           = text.char_in;
    assign b_alpha     = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    assign b_digit     = (b >= "0" && b <= "9");
    assign b_pend_op   = (b == "+") || (b == "-") || (b == "=") || (b == "&")
                       || (b == "|") || (b == "!");
    assign b_single_op = (b == "*") || (b == "/") || (b == "%");

    always_comb
    begin
        pair_cls = 4'd0;
        case (state_reg.pend)
            "+": if (b == "+") pair_cls = CLS_INCR;
            "-": if (b == "-") pair_cls = CLS_DECR;
            "=": if (b == "=") pair_cls = CLS_RELATIONAL;
            "&": if (b == "&") pair_cls = CLS_AND;
            "|": if (b == "|") pair_cls = CLS_OR;
            "!": if (b == "=") pair_cls = CLS_RELATIONAL;
            default: pair_cls = 4'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        res        = '0;
        if ((state_reg.mode == MODE_WORD && (b_alpha || b_digit))
            || (state_reg.mode == MODE_NUMBER && b_digit)) begin
            state_next = extend(state_reg, b);
        end else if (state_reg.mode == MODE_PENDING && pair_cls != 4'd0) begin
            res = push(res, mk_tok(pair_cls, state_reg.start, 8'd2, 5'd0,
                                   state_reg.pend, 1'b0));
            state_next.mode = MODE_IDLE;
            state_next.pend = 8'd0;
        end else begin
            res = emit_open(res, state_reg);
            state_next.mode = MODE_IDLE;
            state_next.pend = 8'd0;
            if (b_alpha || b_digit) begin
                state_next.mode  = b_alpha ? MODE_WORD : MODE_NUMBER;
                state_next.start = state_reg.pos;
                state_next.len   = 8'd0;
                state_next.ovf   = 1'b0;
                state_next.cand  = {KEYWORD_COUNT{1'b1}};
                state_next       = extend(state_next, b);
            end else if (b_pend_op) begin
                state_next.mode  = MODE_PENDING;
                state_next.pend  = b;
                state_next.start = state_reg.pos;
            end else if (b_single_op) begin
                res = push(res, mk_tok(CLS_ARITH, state_reg.pos, 8'd1, 5'd0, b, 1'b0));
            end
        end
        state_next.pos = state_reg.pos + pos_t'(1);
        if (text.end_of_text) begin
            res        = emit_open(res, state_next);
            state_next = LEX_RESET;
        end
        // Mark the final token of this byte.
        if (res.v1) begin
            res.t1.last_of_run = 1'b1;
        end else if (res.v0) begin
            res.t0.last_of_run = 1'b1;
        end
    end

    assign text.ready = (count_reg <= 3'd2);
    assign accept     = text.valid && text.ready;
    assign pop        = tokens.valid && tokens.ready;
    assign npush      = accept ? ({1'b0, res.v0} + {1'b0, res.v1}) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= LEX_RESET;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
            end
            wr_ptr_reg <= wr_ptr_reg + npush;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_reg + {1'b0, npush} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res.v0) begin
            queue_reg[wr_ptr_reg] <= res.t0;
        end
        if (accept && res.v1) begin
            queue_reg[wr_ptr_reg + 2'd1] <= res.t1;
        end
    end

    tok_t head;
    assign head = queue_reg[rd_ptr_reg];

    assign tokens.valid           = (count_reg != 3'd0);
    assign tokens.token_class     = head.token_class;
    assign tokens.token_start     = head.token_start;
    assign tokens.token_length    = head.token_length;
    assign tokens.keyword_index   = head.keyword_index;
    assign tokens.operator_char   = head.operator_char;
    assign tokens.length_overflow = head.length_overflow;
    assign tokens.last_of_run     = head.last_of_run;

endmodule
`default_nettype wire

>>> design/ctl_checker.sv
// Port-level checks on the lexer token stream, bound to c_token_lexer_unit.
`default_nettype none
`include "c_token_lexer_unit_defines.svh"
module ctl_checker
    import ctl_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        tok_valid,
    input wire logic        tok_ready,
    input wire logic [3:0]  token_class,
    input wire logic [15:0] token_start,
    input wire logic [7:0]  token_length,
    input wire logic [4:0]  keyword_index,
    input wire logic [7:0]  operator_char,
    input wire logic        length_overflow,
    input wire logic        last_of_run
);

    logic is_word_or_num;
    logic stalled;

    assign is_word_or_num = (token_class == CLS_KEYWORD) || (token_class == CLS_IDENTIFIER)
                          || (token_class == CLS_NUMBER);
    assign stalled        = tok_valid && !tok_ready;

    // Operators are one or two bytes, never overflow, and carry their byte.
    `CTL_ASSERT_NOW(a_op_shape, tok_valid && !is_word_or_num,
        (token_length == 8'd1 || token_length == 8'd2) && !length_overflow
        && keyword_index == 5'd0 && operator_char != 8'd0)
    // Words and numbers carry no operator byte and a length within the cap.
    `CTL_ASSERT_NOW(a_word_shape, tok_valid && is_word_or_num,
        operator_char == 8'd0 && token_length != 8'd0
        && token_length <= 8'(MAX_TOKEN_LEN))
    // A keyword never ran long and fits the longest table entry.
    `CTL_ASSERT_NOW(a_kw_shape, tok_valid && token_class == CLS_KEYWORD,
        !length_overflow && token_length <= 8'(KW_MAX_LEN)
        && keyword_index < 5'(KEYWORD_COUNT))
    // Hold a stalled beat: valid, class, start, length and last_of_run stay.
    `CTL_ASSERT_NEXT(a_hold, stalled,
        tok_valid && $stable(token_class) && $stable(token_start)
        && $stable(token_length) && $stable(last_of_run))

endmodule

bind c_token_lexer_unit ctl_checker u_ctl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tok_valid       (tokens.valid),
    .tok_ready       (tokens.ready),
    .token_class     (tokens.token_class),
    .token_start     (tokens.token_start),
    .token_length    (tokens.token_length),
    .keyword_index   (tokens.keyword_index),
    .operator_char   (tokens.operator_char),
    .length_overflow (tokens.length_overflow),
    .last_of_run     (tokens.last_of_run)
);
`default_nettype wire
